### design/cidst_pkg.sv
// shared types, constants and helpers for the connection id slot table
`timescale 1ns / 1ps

package cidst_pkg;

    localparam int SLOTS        = 4;
    localparam int IDX_W        = $clog2(SLOTS);
    localparam int SEQ_W        = 62;
    localparam int MAX_OUT      = 4;
    localparam int CNT_W        = $clog2(MAX_OUT + 1);
    localparam int FREED_IDX_W  = $clog2(MAX_OUT);
    localparam int ID_BYTES     = 20;
    localparam int ID_BITS      = 8 * ID_BYTES;
    localparam int LEN_W        = 5;
    localparam int TOKEN_LEN    = 16;
    localparam int TOKEN_HALF_W = 4 * TOKEN_LEN;

    localparam logic [1:0] CMD_REGISTER     = 2'd0;
    localparam logic [1:0] CMD_RETIRE       = 2'd1;
    localparam logic [1:0] CMD_RETIRE_PRIOR = 2'd2;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_LIMIT     = 2'd1;
    localparam logic [1:0] STATUS_VIOLATION = 2'd2;
    localparam logic [1:0] STATUS_NONE      = 2'd3;

    typedef struct packed {
        logic [1:0]              command;
        logic [SEQ_W-1:0]        sequence_req;
        logic [63:0]             cid_word0;
        logic [63:0]             cid_word1;
        logic [31:0]             cid_word2;
        logic [LEN_W-1:0]        cid_length;
        logic [TOKEN_HALF_W-1:0] token_high;
        logic [TOKEN_HALF_W-1:0] token_low;
    } t_in;

    typedef struct packed {
        logic [1:0]       status;
        logic             retired_valid;
        logic [SEQ_W-1:0] retired_sequence;
        logic             current_valid;
        logic [SEQ_W-1:0] current_sequence;
        logic             last;
    } t_out;

    // one row of the id store
    typedef struct packed {
        logic [63:0]             cid_low;
        logic [63:0]             cid_mid;
        logic [31:0]             cid_high;
        logic [LEN_W-1:0]        cid_length;
        logic [TOKEN_HALF_W-1:0] token_high;
        logic [TOKEN_HALF_W-1:0] token_low;
    } t_entry;

    // everything the result stage needs for one command
    typedef struct packed {
        logic [1:0]                    status;
        logic [CNT_W-1:0]              count;
        logic [CNT_W-1:0]              nfreed;
        logic [MAX_OUT-1:0][SEQ_W-1:0] freed;
        logic                          current_valid;
        logic [SEQ_W-1:0]              current_sequence;
    } t_result_set;

    // zero the id bytes past the (clamped) length
    function automatic t_entry make_entry(t_in d);
        logic [ID_BITS-1:0] id;
        logic [LEN_W-1:0]   eff;
        t_entry             e;
        id  = {d.cid_word0, d.cid_word1, d.cid_word2};
        eff = (d.cid_length > LEN_W'(ID_BYTES)) ? LEN_W'(ID_BYTES) : d.cid_length;
        for (int b = 0; b < ID_BYTES; b++) begin
            if (LEN_W'(b) >= eff) begin
                id[ID_BITS-1-8*b -: 8] = 8'h00;
            end
        end
        e.cid_low    = id[ID_BITS-1 -: 64];
        e.cid_mid    = id[ID_BITS-65 -: 64];
        e.cid_high   = id[31:0];
        e.cid_length = d.cid_length;
        e.token_high = d.token_high;
        e.token_low  = d.token_low;
        return e;
    endfunction

endpackage

### design/connection_id_slot_table_top.sv
// connection id slot table: slot sequencer, id store and result stage
`timescale 1ns / 1ps

// usage
//   input channel (i_valid / o_ready / i_in) carries one command per transfer:
//   register an id, retire one sequence, or retire everything below a bound
//   output channel (o_valid / i_ready / o_out) returns 1 to 4 result transfers
//   per command, the final one flagged by last; retire-prior-to gives one
//   transfer per freed sequence, or a single one when none is freed
//   path from the input transfer to the first result transfer: a register past
//   the limit or an unknown command goes straight to the result stage; register
//   otherwise visits the slots in turn, reading and comparing the id store row
//   of each active slot, and stops at the first id or sequence match;
//   retire-prior-to visits every slot, then promotes; retire one does the same
//   unless it frees a slot other than slot 0, where it ends without promotion
//   throughput: one command at a time; the next input transfer is taken once
//   the last result of the previous command has been transferred
//   reset: all slots inactive, slot i expects sequence i, the id store holds
//   garbage until written (only active slots are ever read)
//   a stalled receiver simply holds the result stage and o_ready stays low
//   slot 0 is the id in use; promotion swaps row pointers instead of copying
module connection_id_slot_table_top (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  cidst_pkg::t_in  i_in,
    output logic            o_valid,
    input  logic            i_ready,
    output cidst_pkg::t_out o_out
);
    import cidst_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_VISIT,
        S_CMP,
        S_PROMOTE,
        S_DONE
    } t_state;

    t_state            r_state;
    logic [IDX_W-1:0]  r_idx;
    logic [1:0]        r_cmd;
    logic [SEQ_W-1:0]  r_seq;
    t_entry            r_entry;
    logic [1:0]        r_status;
    logic              r_stored;
    logic              r_retired;
    logic [CNT_W-1:0]  r_nfreed;
    logic [MAX_OUT-1:0][SEQ_W-1:0] r_freed;
    logic              r_min_found;
    logic [SEQ_W-1:0]  r_min_seq;
    logic [IDX_W-1:0]  r_min_idx;

    // per-slot control state
    logic [SEQ_W-1:0]  r_seq_tab [SLOTS];
    logic [SLOTS-1:0]  r_act;
    logic [IDX_W-1:0]  r_map [SLOTS];   // slot -> id store row
    logic [SEQ_W-1:0]  r_largest;

    logic [SEQ_W-1:0]  w_cur_seq;
    logic              w_cur_act;
    logic              w_seq_hit;
    logic              w_last_slot;
    logic [SEQ_W-1:0]  w_inc_largest;
    logic              w_min_take;
    logic              w_we;
    t_entry            w_rdata;
    logic              w_id_eq;
    logic              w_tok_eq;
    logic              w_emit_busy;
    logic              w_load;
    t_result_set       w_set;

    assign w_cur_seq     = r_seq_tab[r_idx];
    assign w_cur_act     = r_act[r_idx];
    assign w_seq_hit     = (w_cur_seq == r_seq);
    assign w_last_slot   = (r_idx == IDX_W'(SLOTS - 1));
    assign w_inc_largest = (&r_largest) ? r_largest : r_largest + SEQ_W'(1);
    assign w_min_take    = !r_min_found || (w_cur_seq < r_min_seq);

    // store a new id into a free slot that expects this sequence
    assign w_we = (r_state == S_VISIT) && (r_cmd == CMD_REGISTER) && !w_cur_act &&
                  w_seq_hit && !r_stored;

    assign w_id_eq  = (w_rdata.cid_length == r_entry.cid_length) &&
                      (w_rdata.cid_low == r_entry.cid_low) &&
                      (w_rdata.cid_mid == r_entry.cid_mid) &&
                      (w_rdata.cid_high == r_entry.cid_high);
    assign w_tok_eq = (w_rdata.token_high == r_entry.token_high) &&
                      (w_rdata.token_low == r_entry.token_low);

    cidst_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_map[r_idx]),
        .i_wdata (r_entry),
        .i_raddr (r_map[r_idx]),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_idx     <= '0;
            r_act     <= '0;
            r_largest <= SEQ_W'(SLOTS - 1);
            for (int i = 0; i < SLOTS; i++) begin
                r_seq_tab[i] <= SEQ_W'(i);
                r_map[i]     <= IDX_W'(i);
            end
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_cmd       <= i_in.command;
                        r_seq       <= i_in.sequence_req;
                        r_entry     <= make_entry(i_in);
                        r_idx       <= '0;
                        r_status    <= STATUS_OK;
                        r_stored    <= 1'b0;
                        r_retired   <= 1'b0;
                        r_nfreed    <= '0;
                        r_min_found <= 1'b0;
                        priority if (i_in.command == CMD_REGISTER) begin
                            if (r_largest < i_in.sequence_req) begin
                                r_status <= STATUS_LIMIT;
                                r_state  <= S_DONE;
                            end else begin
                                r_state <= S_VISIT;
                            end
                        end else if (i_in.command == CMD_RETIRE ||
                                     i_in.command == CMD_RETIRE_PRIOR) begin
                            r_state <= S_VISIT;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end

                S_VISIT: begin
                    priority if (r_cmd == CMD_REGISTER) begin
                        if (w_cur_act) begin
                            // id store read issued this cycle, compare next
                            r_state <= S_CMP;
                        end else begin
                            if (w_seq_hit && !r_stored) begin
                                r_stored <= 1'b1;
                                if (r_idx != '0 && !r_act[0]) begin
                                    // promote into slot 0 by swapping rows
                                    r_seq_tab[0]     <= w_cur_seq;
                                    r_act[0]         <= 1'b1;
                                    r_map[0]         <= r_map[r_idx];
                                    r_act[r_idx]     <= 1'b0;
                                    r_seq_tab[r_idx] <= r_seq_tab[0];
                                    r_map[r_idx]     <= r_map[0];
                                end else begin
                                    r_act[r_idx] <= 1'b1;
                                end
                            end
                            if (w_last_slot) begin
                                r_state <= S_DONE;
                            end else begin
                                r_idx <= r_idx + IDX_W'(1);
                            end
                        end
                    end else if (r_cmd == CMD_RETIRE) begin
                        if (w_seq_hit && w_cur_act) begin
                            r_act[r_idx]     <= 1'b0;
                            r_largest        <= w_inc_largest;
                            r_seq_tab[r_idx] <= w_inc_largest;
                            r_retired        <= 1'b1;
                        end else if (w_cur_act && w_min_take) begin
                            r_min_found <= 1'b1;
                            r_min_seq   <= w_cur_seq;
                            r_min_idx   <= r_idx;
                        end
                        if (w_seq_hit && w_cur_act && r_idx != '0) begin
                            // retiring a non-current slot ends without promotion
                            r_status <= STATUS_OK;
                            r_state  <= S_DONE;
                        end else if (w_last_slot) begin
                            r_state <= S_PROMOTE;
                        end else begin
                            r_idx <= r_idx + IDX_W'(1);
                        end
                    end else begin
                        if (w_cur_act) begin
                            if ((w_cur_seq < r_seq) && (r_nfreed < CNT_W'(MAX_OUT))) begin
                                r_freed[r_nfreed[FREED_IDX_W-1:0]] <= w_cur_seq;
                                r_nfreed         <= r_nfreed + CNT_W'(1);
                                r_act[r_idx]     <= 1'b0;
                                r_largest        <= w_inc_largest;
                                r_seq_tab[r_idx] <= w_inc_largest;
                            end else if (w_min_take) begin
                                r_min_found <= 1'b1;
                                r_min_seq   <= w_cur_seq;
                                r_min_idx   <= r_idx;
                            end
                        end
                        if (w_last_slot) begin
                            r_state <= S_PROMOTE;
                        end else begin
                            r_idx <= r_idx + IDX_W'(1);
                        end
                    end
                end

                S_CMP: begin
                    if (w_id_eq) begin
                        r_status <= (w_seq_hit && w_tok_eq) ? STATUS_OK : STATUS_VIOLATION;
                        r_state  <= S_DONE;
                    end else if (w_seq_hit) begin
                        r_status <= STATUS_VIOLATION;
                        r_state  <= S_DONE;
                    end else if (w_last_slot) begin
                        r_state <= S_DONE;
                    end else begin
                        r_idx   <= r_idx + IDX_W'(1);
                        r_state <= S_VISIT;
                    end
                end

                S_PROMOTE: begin
                    if (!r_act[0] && r_min_found && r_min_idx != '0) begin
                        r_seq_tab[0]         <= r_seq_tab[r_min_idx];
                        r_act[0]             <= 1'b1;
                        r_map[0]             <= r_map[r_min_idx];
                        r_act[r_min_idx]     <= 1'b0;
                        r_seq_tab[r_min_idx] <= r_seq_tab[0];
                        r_map[r_min_idx]     <= r_map[0];
                    end
                    if (r_cmd == CMD_RETIRE && !r_retired) begin
                        r_status <= STATUS_NONE;
                    end
                    r_state <= S_DONE;
                end

                S_DONE: begin
                    r_state <= S_IDLE;
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // hand the finished command to the result stage
    assign w_load = (r_state == S_DONE);

    always_comb begin
        w_set.status           = r_status;
        w_set.nfreed           = r_nfreed;
        w_set.count            = (r_nfreed != '0) ? r_nfreed : CNT_W'(1);
        w_set.freed            = r_freed;
        w_set.current_valid    = r_act[0];
        w_set.current_sequence = r_seq_tab[0];
    end

    cidst_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_load),
        .i_set   (w_set),
        .o_busy  (w_emit_busy),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_out   (o_out)
    );

    // new command only once the previous one's results are all transferred
    assign o_ready = (r_state == S_IDLE) && !w_emit_busy;

endmodule

### design/cidst_ram.sv
// simple dual port ram with registered read data
`timescale 1ns / 1ps

module cidst_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 4,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/cidst_emit.sv
// result stage: holds one command's results and hands them out one per transfer
`timescale 1ns / 1ps

module cidst_emit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  cidst_pkg::t_result_set i_set,
    output logic                  o_busy,
    output logic                  o_valid,
    input  logic                  i_ready,
    output cidst_pkg::t_out       o_out
);
    import cidst_pkg::*;

    t_result_set      r_set;
    logic [CNT_W-1:0] r_k;
    logic             r_valid;
    logic             w_last;

    assign w_last = (r_k == r_set.count - CNT_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_k     <= '0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_k     <= '0;
            r_set   <= i_set;
        end else if (r_valid && i_ready) begin
            if (w_last) begin
                r_valid <= 1'b0;
            end else begin
                r_k <= r_k + CNT_W'(1);
            end
        end
    end

    always_comb begin
        o_out.status           = r_set.status;
        o_out.retired_valid    = (r_k < r_set.nfreed);
        o_out.retired_sequence = o_out.retired_valid ?
                                 r_set.freed[r_k[FREED_IDX_W-1:0]] : '0;
        o_out.current_valid    = r_set.current_valid;
        o_out.current_sequence = r_set.current_sequence;
        o_out.last             = w_last;
    end

    assign o_valid = r_valid;
    assign o_busy  = r_valid;

endmodule

### dv/connection_id_slot_table_top_tb.sv
// self-checking testbench for the connection id slot table
`timescale 1ns / 1ps

module connection_id_slot_table_top_tb;
    import cidst_pkg::*;

    localparam logic [SEQ_W-1:0] SEQ_TOP = {SEQ_W{1'b1}};
    localparam int IDLE_LIMIT = 20000;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_ready;
    t_in  i_in;
    logic o_valid;
    logic i_ready;
    t_out o_out;

    connection_id_slot_table_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_in    (i_in),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_out   (o_out)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // predictor copy of the slot table
    logic [SEQ_W-1:0] tbl_seq [SLOTS];
    logic             tbl_act [SLOTS];
    t_entry           tbl_row [SLOTS];
    logic [SEQ_W-1:0] next_seq_limit;

    t_in  cmd_queue [$];
    t_out result_queue [$];
    int   mismatches;
    int   idle_cycles;
    bit   stim_done;
    bit   timed_out;

    // the ids that register commands draw from, kept small so hits are common
    t_in  id_pool [8];

    // ---------------------------------------------------------------- predictor

    function automatic t_entry clip_id(t_in d);
        logic [ID_BITS-1:0] id;
        int                 eff;
        t_entry             e;
        id  = {d.cid_word0, d.cid_word1, d.cid_word2};
        eff = (d.cid_length > ID_BYTES) ? ID_BYTES : int'(d.cid_length);
        for (int b = eff; b < ID_BYTES; b++) begin
            id[ID_BITS-1-8*b -: 8] = 8'h00;
        end
        e.cid_low    = id[ID_BITS-1 -: 64];
        e.cid_mid    = id[ID_BITS-65 -: 64];
        e.cid_high   = id[31:0];
        e.cid_length = d.cid_length;
        e.token_high = d.token_high;
        e.token_low  = d.token_low;
        return e;
    endfunction

    // move slot idx into the empty slot 0, the old slot 0 sequence goes back
    function automatic void swap_into_current(int idx);
        logic [SEQ_W-1:0] old;
        old = tbl_seq[0];
        if (idx <= 0 || tbl_act[0]) begin
            return;
        end
        tbl_seq[0]   = tbl_seq[idx];
        tbl_act[0]   = tbl_act[idx];
        tbl_row[0]   = tbl_row[idx];
        tbl_act[idx] = 1'b0;
        tbl_seq[idx] = old;
    endfunction

    function automatic void free_slot(int i);
        tbl_act[i] = 1'b0;
        if (next_seq_limit != SEQ_TOP) begin
            next_seq_limit = next_seq_limit + 1'b1;
        end
        tbl_seq[i] = next_seq_limit;
    endfunction

    function automatic logic [1:0] apply_register(t_in d);
        t_entry e;
        bit     stored;
        e      = clip_id(d);
        stored = 0;
        if (d.sequence_req > next_seq_limit) begin
            return STATUS_LIMIT;
        end
        for (int i = 0; i < SLOTS; i++) begin
            if (tbl_act[i]) begin
                if (tbl_row[i].cid_length == e.cid_length && tbl_row[i].cid_low == e.cid_low
                        && tbl_row[i].cid_mid == e.cid_mid
                        && tbl_row[i].cid_high == e.cid_high) begin
                    if (tbl_seq[i] == d.sequence_req && tbl_row[i].token_high == e.token_high
                            && tbl_row[i].token_low == e.token_low) begin
                        return STATUS_OK;
                    end
                    return STATUS_VIOLATION;
                end
                if (tbl_seq[i] == d.sequence_req) begin
                    return STATUS_VIOLATION;
                end
            end else if (tbl_seq[i] == d.sequence_req && !stored) begin
                tbl_row[i] = e;
                tbl_act[i] = 1'b1;
                stored     = 1;
                if (i > 0 && !tbl_act[0]) begin
                    swap_into_current(i);
                end
            end
        end
        return STATUS_OK;
    endfunction

    function automatic logic [1:0] apply_retire(logic [SEQ_W-1:0] s);
        logic [SEQ_W:0] min_seq;
        int             min_idx;
        bit             hit;
        min_seq = {1'b1, SEQ_TOP};
        min_idx = -1;
        hit     = 0;
        for (int i = 0; i < SLOTS; i++) begin
            if (tbl_seq[i] == s && tbl_act[i]) begin
                free_slot(i);
                hit = 1;
                if (i != 0) begin
                    return STATUS_OK;
                end
            end
            if (tbl_act[i] && min_seq > {1'b0, tbl_seq[i]}) begin
                min_seq = {1'b0, tbl_seq[i]};
                min_idx = i;
            end
        end
        if (!tbl_act[0] && min_idx > 0) begin
            swap_into_current(min_idx);
        end
        return hit ? STATUS_OK : STATUS_NONE;
    endfunction

    // works out the results of one command and queues them
    task automatic predict_results(t_in d);
        logic [SEQ_W-1:0] freed [MAX_OUT];
        logic [1:0]       st;
        int               n;
        int               cnt;
        logic [SEQ_W:0]   min_seq;
        int               min_idx;
        t_out             r;
        st  = STATUS_OK;
        n   = 0;
        if (d.command == CMD_REGISTER) begin
            st = apply_register(d);
        end else if (d.command == CMD_RETIRE) begin
            st = apply_retire(d.sequence_req);
        end else if (d.command == CMD_RETIRE_PRIOR) begin
            min_seq = {1'b1, SEQ_TOP};
            min_idx = -1;
            for (int i = 0; i < SLOTS; i++) begin
                if (tbl_act[i]) begin
                    if (tbl_seq[i] < d.sequence_req && n < MAX_OUT) begin
                        freed[n] = tbl_seq[i];
                        n++;
                        free_slot(i);
                    end else if (min_seq > {1'b0, tbl_seq[i]}) begin
                        min_seq = {1'b0, tbl_seq[i]};
                        min_idx = i;
                    end
                end
            end
            if (!tbl_act[0] && min_idx > 0) begin
                swap_into_current(min_idx);
            end
        end
        cnt = (n > 0) ? n : 1;
        for (int k = 0; k < cnt; k++) begin
            r.status           = st;
            r.retired_valid    = (k < n);
            r.retired_sequence = (k < n) ? freed[k] : '0;
            r.current_valid    = tbl_act[0];
            r.current_sequence = tbl_seq[0];
            r.last             = (k == cnt - 1);
            result_queue.push_back(r);
        end
    endtask

    // ---------------------------------------------------------------- stimulus

    function automatic t_in make_cmd(logic [1:0] c, logic [SEQ_W-1:0] s, int pick);
        t_in d;
        d              = id_pool[pick];
        d.command      = c;
        d.sequence_req = s;
        return d;
    endfunction

    function automatic logic [SEQ_W-1:0] rand_seq62();
        return SEQ_W'({$urandom(), $urandom()});
    endfunction

    function automatic t_in rand_id();
        t_in d;
        d.command      = CMD_REGISTER;
        d.sequence_req = '0;
        d.cid_word0    = {$urandom(), $urandom()};
        d.cid_word1    = {$urandom(), $urandom()};
        d.cid_word2    = $urandom();
        d.cid_length   = LEN_W'($urandom_range(0, 31));
        d.token_high   = {$urandom(), $urandom()};
        d.token_low    = {$urandom(), $urandom()};
        return d;
    endfunction

    initial begin
        t_in d;
        int  base;
        for (int i = 0; i < 8; i++) begin
            id_pool[i] = rand_id();
        end
        // corner ids: full length, zero length, length past twenty, all ones, all zeros
        id_pool[0].cid_length = 5'd20;
        id_pool[1].cid_length = 5'd0;
        id_pool[2].cid_length = 5'd31;
        id_pool[3] = '1;
        id_pool[4] = '0;

        // directed part
        cmd_queue.push_back(make_cmd(CMD_RETIRE, 0, 0));            // retire on an empty table
        cmd_queue.push_back(make_cmd(CMD_RETIRE_PRIOR, SEQ_TOP, 0)); // nothing to free
        cmd_queue.push_back(make_cmd(CMD_REGISTER, SEQ_TOP, 3));     // beyond the limit
        cmd_queue.push_back(make_cmd(CMD_REGISTER, 2, 0));           // promoted into slot 0
        cmd_queue.push_back(make_cmd(CMD_REGISTER, 2, 0));           // exact duplicate
        d = make_cmd(CMD_REGISTER, 2, 0);
        d.token_low = ~d.token_low;
        cmd_queue.push_back(d);                                       // same id, other token
        cmd_queue.push_back(make_cmd(CMD_REGISTER, 2, 1));           // sequence taken
        cmd_queue.push_back(make_cmd(CMD_REGISTER, 0, 1));
        cmd_queue.push_back(make_cmd(CMD_REGISTER, 1, 2));
        cmd_queue.push_back(make_cmd(CMD_REGISTER, 3, 3));
        cmd_queue.push_back(make_cmd(CMD_RETIRE, 1, 0));             // expected, retired
        cmd_queue.push_back(make_cmd(CMD_REGISTER, 1, 4));           // already retired
        cmd_queue.push_back(make_cmd(CMD_RETIRE, 5, 0));             // beyond the limit, not in the table
        cmd_queue.push_back(make_cmd(CMD_REGISTER, 4, 4));
        cmd_queue.push_back(make_cmd(CMD_RETIRE_PRIOR, SEQ_TOP, 0)); // frees all four
        cmd_queue.push_back(make_cmd(2'd3, SEQ_TOP, 3));             // unknown command
        for (int i = 0; i < 4; i++) begin
            cmd_queue.push_back(make_cmd(CMD_REGISTER, SEQ_W'(8 + i), i + 4));
        end
        cmd_queue.push_back(make_cmd(CMD_RETIRE_PRIOR, 10, 0));      // frees the one live slot
        cmd_queue.push_back(make_cmd(CMD_RETIRE, 10, 0));            // no live slot holds it

        // random part: mostly sequences near the live window
        base = 8;
        for (int n = 0; n < 145; n++) begin
            int roll;
            logic [SEQ_W-1:0] s;
            roll = $urandom_range(0, 99);
            s    = SEQ_W'(base + $urandom_range(0, 10));
            if (roll < 5) begin
                s = rand_seq62();
            end
            if ($urandom_range(0, 3) == 0) begin
                id_pool[$urandom_range(5, 7)] = rand_id();
            end
            if (roll < 50) begin
                cmd_queue.push_back(make_cmd(CMD_REGISTER, s, $urandom_range(0, 7)));
            end else if (roll < 75) begin
                cmd_queue.push_back(make_cmd(CMD_RETIRE, s, 0));
            end else if (roll < 96) begin
                cmd_queue.push_back(make_cmd(CMD_RETIRE_PRIOR, s, 0));
                base = base + $urandom_range(0, 3);
            end else begin
                cmd_queue.push_back(make_cmd(2'd3, rand_seq62(), $urandom_range(0, 7)));
            end
        end
        // repeatedly register and then retire everything
        for (int n = 0; n < 6; n++) begin
            cmd_queue.push_back(make_cmd(CMD_REGISTER, SEQ_W'(base + 20), $urandom_range(0, 7)));
            cmd_queue.push_back(make_cmd(CMD_RETIRE_PRIOR, SEQ_TOP, 0));
        end
        cmd_queue.push_back(make_cmd(CMD_REGISTER, SEQ_TOP - 1, 0));
    end

    // ---------------------------------------------------------------- reset and table init

    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            tbl_seq[i] = SEQ_W'(i);
            tbl_act[i] = 1'b0;
            tbl_row[i] = '0;
        end
        next_seq_limit = SEQ_W'(SLOTS - 1);
        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // ---------------------------------------------------------------- driver

    int burst_left;
    int gap_left;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid    <= 1'b0;
            i_in       <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end else if (!i_valid || o_ready) begin
            // the previous command, if any, was transferred at this edge
            if (i_valid) begin
                predict_results(i_in);
            end
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                i_valid  <= 1'b0;
            end else if (cmd_queue.size() > 0) begin
                i_in    <= cmd_queue.pop_front();
                i_valid <= 1'b1;
                if (burst_left == 0) begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- receiver stall pattern

    logic [15:0] stall_lfsr;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            // low bit forced so the register never starts all zero
            stall_lfsr <= (16'hACE1 ^ 16'($urandom())) | 16'h0001;
            i_ready    <= 1'b0;
        end else begin
            stall_lfsr <= {stall_lfsr[14:0],
                           stall_lfsr[15] ^ stall_lfsr[13] ^ stall_lfsr[12] ^ stall_lfsr[10]};
            // long open windows in the upper quarter, choppy otherwise
            if (stall_lfsr[15:14] == 2'b11) begin
                i_ready <= 1'b1;
            end else begin
                i_ready <= stall_lfsr[3] | stall_lfsr[7];
            end
        end
    end

    // ---------------------------------------------------------------- monitor

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            mismatches  <= 0;
            idle_cycles <= 0;
        end else begin
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (o_valid && i_ready) begin
                // results of a command are predicted at its own input transfer
                if (result_queue.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("unexpected result transfer: %p", o_out);
                    end
                    mismatches <= mismatches + 1;
                end else begin
                    want = result_queue.pop_front();
                    if (o_out !== want) begin
                        if (mismatches < 10) begin
                            $display("result mismatch at %0t", $time);
                            $display("  expected %p", want);
                            $display("  actual   %p", o_out);
                        end
                        mismatches <= mismatches + 1;
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------- end of test

    initial begin
        timed_out = 0;
        stim_done = 0;
        @(posedge i_rst_n);
        fork
            begin
                wait (cmd_queue.size() == 0 && !i_valid && result_queue.size() == 0);
                repeat (4 * SLOTS + 10) @(posedge i_clk);
                stim_done = 1;
            end
            begin
                wait (idle_cycles >= IDLE_LIMIT);
                timed_out = 1;
            end
        join_any
        disable fork;
        if (timed_out) begin
            $display("[FAIL] regression broken");
        end else if (mismatches == 0 && result_queue.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

### filelist.f
design/cidst_pkg.sv
design/cidst_ram.sv
design/cidst_emit.sv
design/connection_id_slot_table_top.sv
dv/connection_id_slot_table_top_tb.sv
